// ===== rtl/utf8_ucs2_transcoder_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the UTF-8 / UCS-2 transcoder
// Shared helpers for concurrent checks, clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef UTF8_UCS2_TRANSCODER_MACROS_SVH
`define UTF8_UCS2_TRANSCODER_MACROS_SVH

// Same-cycle implication.
`define UTX_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("transcoder check failed");

// Next-cycle implication.
`define UTX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("transcoder check failed");

`endif

// ===== rtl/utx_pkg.sv =====
// ---------------------------------------------------------------------------
// utx_pkg
// Types and constants shared by the transcoder front end, queue and back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package utx_pkg;

  // Number of results a job expands to.
  localparam logic [1:0] NRES_ONE   = 2'd1;
  localparam logic [1:0] NRES_TWO   = 2'd2;
  localparam logic [1:0] NRES_THREE = 2'd3;

  // Continuation bytes still expected while decoding.
  localparam logic [1:0] PEND_IDLE = 2'd0;
  localparam logic [1:0] PEND_ONE  = 2'd1;
  localparam logic [1:0] PEND_TWO  = 2'd2;

  // Register index of the direction register.
  localparam logic REG_DIRECTION = 1'b0;

  // Direction codes.
  localparam logic DIR_DECODE = 1'b0;
  localparam logic DIR_ENCODE = 1'b1;

  // Job queue depth (pointers are one bit wide).
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [15:0] value;
    logic [1:0]  nres;
    logic        string_end;
    logic        truncated;
  } job_t;

endpackage

// ===== rtl/utf8_ucs2_transcoder.sv =====
// An accepted request goes into the job queue, then its first result into
// the output register; lead and middle UTF-8 bytes produce no result.
// Throughput: one request per cycle while the queue has room. An encoded unit
// gives one to three bytes, one per cycle while out_ready does not stall it.
// Reset (rst_n low, synchronous) sets direction to decode, clears the decode
// state and empties the job queue and output register.
// ---------------------------------------------------------------------------
// utf8_ucs2_transcoder
// Streaming UTF-8 <-> UCS-2 transcoder with an APB-style direction register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_ucs2_transcoder (
  input  logic        clk,
  input  logic        rst_n,
  // Input request channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_code_unit,
  // Result channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_value,
  output logic        out_last_of_run,
  output logic        out_string_end,
  output logic        out_truncated,
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // The direction register lives here. Any write to it also clears the
  // partial UTF-8 sequence held in the front end. Register index is byte
  // address divided by four, so bit 2 selects it; writes past the list drop.
  logic          direction_r;
  logic          dir_write;
  logic          reg_hit;

  // Front end to queue, queue to back end.
  logic          in_accept;
  logic          push;
  utx_pkg::job_t push_job;
  utx_pkg::job_t head;
  logic          q_empty;
  logic          q_full;
  logic          pop;

  assign cfg_pready = 1'b1;
  assign reg_hit    = (cfg_paddr[2] == utx_pkg::REG_DIRECTION);
  assign dir_write  = cfg_psel && cfg_penable && cfg_pwrite && reg_hit;
  assign cfg_prdata = reg_hit ? {31'h0, direction_r} : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= utx_pkg::DIR_DECODE;
    end else if (dir_write) begin
      direction_r <= cfg_pwdata[0];
    end
  end

  // The front end takes a request whenever the queue has room; it does not
  // wait on the output side. Requests that finish no unit push nothing.
  assign in_ready  = !q_full;
  assign in_accept = in_valid && in_ready;

  utx_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .direction (direction_r),
    .clear     (dir_write),
    .accept    (in_accept),
    .code_unit (in_code_unit),
    .push      (push),
    .job       (push_job)
  );

  // Two jobs of slack let an encoded three-byte run drain while the next
  // request is already classified.
  utx_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // The back end walks each job one result per cycle while out_ready allows and
  // retires it from the queue as its final result moves into the output register.
  utx_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .empty           (q_empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_value       (out_value),
    .out_last_of_run (out_last_of_run),
    .out_string_end  (out_string_end),
    .out_truncated   (out_truncated)
  );

endmodule

// ===== rtl/utx_front.sv =====
// ---------------------------------------------------------------------------
// utx_front
// Accepts input units, runs the UTF-8 decode state and classifies each finished
// item into a job of one to three results for the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module utx_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              direction,
  input  logic              clear,
  input  logic              accept,
  input  logic [15:0]       code_unit,
  output logic              push,
  output utx_pkg::job_t     job
);

  logic [1:0]  bytes_pending_r, bytes_pending_nxt;
  logic [15:0] partial_value_r, partial_value_nxt;
  logic [1:0]  pend;
  logic [7:0]  b;
  logic [7:0]  cont;
  logic [15:0] u;

  assign b    = code_unit[7:0];
  assign cont = b ^ 8'h80;
  assign u    = code_unit;
  // A pending count of three cannot occur; it reads as idle.
  assign pend = (bytes_pending_r == 2'd3) ? utx_pkg::PEND_IDLE : bytes_pending_r;

  always_comb begin
    bytes_pending_nxt = bytes_pending_r;
    partial_value_nxt = partial_value_r;
    push              = 1'b0;
    job.value         = 16'h0000;
    job.nres          = utx_pkg::NRES_ONE;
    job.string_end    = 1'b0;
    job.truncated     = 1'b0;
    if (direction == utx_pkg::DIR_ENCODE) begin
      push      = accept;
      job.value = u;
      priority if (u == 16'h0000) begin
        job.string_end = 1'b1;
      end else if (u < 16'h0080) begin
        job.nres = utx_pkg::NRES_ONE;
      end else if (u < 16'h0800) begin
        job.nres = utx_pkg::NRES_TWO;
      end else begin
        job.nres = utx_pkg::NRES_THREE;
      end
    end else if (b == 8'h00) begin
      push              = accept;
      job.string_end    = 1'b1;
      job.truncated     = (pend != utx_pkg::PEND_IDLE);
      bytes_pending_nxt = utx_pkg::PEND_IDLE;
      partial_value_nxt = 16'h0000;
    end else begin
      unique case (pend)
        utx_pkg::PEND_TWO: begin
          bytes_pending_nxt = utx_pkg::PEND_ONE;
          partial_value_nxt = partial_value_r | {2'b00, cont, 6'b000000};
        end
        utx_pkg::PEND_ONE: begin
          push              = accept;
          job.value         = partial_value_r | {8'h00, cont};
          bytes_pending_nxt = utx_pkg::PEND_IDLE;
          partial_value_nxt = 16'h0000;
        end
        default: begin
          priority if (b < 8'h80) begin
            push      = accept;
            job.value = {8'h00, b};
          end else if (b < 8'hE0) begin
            bytes_pending_nxt = utx_pkg::PEND_ONE;
            partial_value_nxt = {5'b00000, b[4:0], 6'b000000};
          end else begin
            bytes_pending_nxt = utx_pkg::PEND_TWO;
            partial_value_nxt = {b[3:0], 12'h000};
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      bytes_pending_r <= utx_pkg::PEND_IDLE;
      partial_value_r <= 16'h0000;
    end else if (accept && direction == utx_pkg::DIR_DECODE) begin
      bytes_pending_r <= bytes_pending_nxt;
      partial_value_r <= partial_value_nxt;
    end
  end

endmodule

// ===== rtl/utx_queue.sv =====
// ---------------------------------------------------------------------------
// utx_queue
// Two-entry job queue between the front end and the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "utf8_ucs2_transcoder_macros.svh"

module utx_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  utx_pkg::job_t push_job,
  input  logic          pop,
  output utx_pkg::job_t head,
  output logic          empty,
  output logic          full
);

  utx_pkg::job_t mem_r [utx_pkg::QUEUE_DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign empty = (count_r == 2'd0);
  assign full  = (count_r == 2'(utx_pkg::QUEUE_DEPTH));
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  `UTX_ASSERT_NOW(a_no_overflow, clk, rst_n, push, !full)
  `UTX_ASSERT_NOW(a_no_underflow, clk, rst_n, pop, !empty)
  `UTX_ASSERT_NOW(a_count_range, clk, rst_n, 1'b1, count_r != 2'd3)
  `UTX_ASSERT_NEXT(a_ptr_gap, clk, rst_n, 1'b1,
                   (count_r == 2'd1) == (wr_ptr_r != rd_ptr_r))

endmodule

// ===== rtl/utx_back.sv =====
// ---------------------------------------------------------------------------
// utx_back
// Expands queued jobs into UTF-8 bytes or UCS-2 units through the output
// register, one result per cycle while out_ready does not stall it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module utx_back (
  input  logic          clk,
  input  logic          rst_n,
  input  utx_pkg::job_t head,
  input  logic          empty,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [15:0]   out_value,
  output logic          out_last_of_run,
  output logic          out_string_end,
  output logic          out_truncated
);

  logic [1:0]  idx_r, idx_nxt;
  logic        valid_r, valid_nxt;
  logic [15:0] value_r, value_nxt;
  logic        last_r, end_r, trunc_r;
  logic        load;
  logic        last;
  logic [15:0] u;

  assign u    = head.value;
  assign load = !empty && (!valid_r || out_ready);
  assign last = (idx_r == head.nres - 2'd1);
  assign pop  = load && last;

  always_comb begin
    idx_nxt   = load ? (last ? 2'd0 : idx_r + 2'd1) : idx_r;
    valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);
    value_nxt = u;
    unique case (head.nres)
      utx_pkg::NRES_TWO: begin
        value_nxt = (idx_r == 2'd0) ? {8'h00, 3'b110, u[10:6]}
                                    : {8'h00, 2'b10, u[5:0]};
      end
      utx_pkg::NRES_THREE: begin
        unique case (idx_r)
          2'd0:    value_nxt = {8'h00, 4'b1110, u[15:12]};
          2'd1:    value_nxt = {8'h00, 2'b10, u[11:6]};
          default: value_nxt = {8'h00, 2'b10, u[5:0]};
        endcase
      end
      default: value_nxt = u;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value_r <= value_nxt;
      last_r  <= last;
      end_r   <= head.string_end;
      trunc_r <= head.truncated;
    end
  end

  assign out_valid       = valid_r;
  assign out_value       = value_r;
  assign out_last_of_run = last_r;
  assign out_string_end  = end_r;
  assign out_truncated   = trunc_r;

endmodule
